// ===== hdl/weigh_dispense_controller_top_macros.svh =====
// Assertion macros shared by the checker of the weigh and dispense controller.
`ifndef WEIGH_DISPENSE_CONTROLLER_TOP_MACROS_SVH
`define WEIGH_DISPENSE_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define WDC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define WDC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/wdc_pkg.sv =====
// Types and constants shared by the weigh and dispense controller modules.
package wdc_pkg;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CHARGE = 1'b1;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_TIMEOUT = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TREND_PERIOD = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_PROGRESS = 2'd3;

	localparam logic [15:0] RELEASE_TIMEOUT_RESET = 16'd60;
	localparam logic [15:0] TREND_PERIOD_RESET = 16'd60;
	localparam logic [7:0] TOLERANCE_RESET = 8'd26;
	localparam logic [15:0] MIN_PROGRESS_RESET = 16'd160;

	// Default target of 100 grams in sixteenths of a gram.
	localparam int TARGET_RESET = 1600;

	localparam int ADD_BITS = 19;
	localparam int TIME_BITS = 32;

	typedef struct packed {
		logic [15:0] release_timeout_s;
		logic [15:0] trend_period;
		logic [7:0] tolerance_q8;
		logic [15:0] min_progress;
	} cfg_t;

	typedef struct packed {
		logic motor_on;
		logic storage_empty;
		logic load_increased;
		logic load_decreased;
	} flags_t;

endpackage

// ===== hdl/wdc_trend.sv =====
// Trend comparison of the new load against the saved load with a relative tolerance.
module wdc_trend import wdc_pkg::*; #(
	parameter int WEIGHT_BITS = 20
) (
	input logic signed [WEIGHT_BITS-1:0] saved_load,
	input logic signed [WEIGHT_BITS-1:0] load,
	input logic [7:0] tolerance_q8,
	output logic fall,
	output logic rise
);

	localparam int PW = WEIGHT_BITS + 11;

	logic signed [PW-1:0] lhs;
	logic signed [PW-1:0] load_x;
	logic signed [PW-1:0] k_hi;
	logic signed [PW-1:0] k_lo;
	logic signed [PW-1:0] rhs_hi;
	logic signed [PW-1:0] rhs_lo;
	logic [8:0] lo_factor;

	assign lhs = {{3{saved_load[WEIGHT_BITS-1]}}, saved_load, 8'b0};
	assign load_x = {{11{load[WEIGHT_BITS-1]}}, load};
	assign lo_factor = 9'd256 - {1'b0, tolerance_q8};
	assign k_hi = {{(PW-9){1'b0}}, 1'b1, tolerance_q8};
	assign k_lo = {{(PW-9){1'b0}}, lo_factor};
	assign rhs_hi = load_x * k_hi;
	assign rhs_lo = load_x * k_lo;
	assign fall = lhs > rhs_hi;
	assign rise = lhs < rhs_lo;

endmodule

// ===== hdl/wdc_state.sv =====
// Dosing and trend state of the controller with its next-state logic.
module wdc_state import wdc_pkg::*; #(
	parameter int WEIGHT_BITS = 20
) (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input cfg_t cfg,
	input logic cmd,
	input logic signed [WEIGHT_BITS-1:0] weight,
	input logic [ADD_BITS-1:0] add_amount,
	input logic [TIME_BITS-1:0] now_s,
	output flags_t flags_nx,
	output logic signed [WEIGHT_BITS-1:0] current_load_nx,
	output logic signed [WEIGHT_BITS-1:0] reference_load_nx
);

	localparam int TW = (WEIGHT_BITS > ADD_BITS + 1 ? WEIGHT_BITS : ADD_BITS + 1) + 1;
	localparam int BW = (WEIGHT_BITS > 16 ? WEIGHT_BITS : 16) + 1;

	logic charging_q, charging_nx;
	logic signed [WEIGHT_BITS-1:0] load_q, load_nx;
	logic signed [TW-1:0] target_q, target_nx;
	logic signed [WEIGHT_BITS-1:0] base_q, base_nx;
	logic [TIME_BITS-1:0] start_q, start_nx;
	logic [15:0] count_q, count_nx;
	logic signed [WEIGHT_BITS-1:0] saved_q, saved_nx;
	logic rise_q, rise_nx;
	logic fall_q, fall_nx;

	logic empty;
	logic [TIME_BITS-1:0] elapsed;
	logic signed [BW-1:0] gain;
	logic signed [BW-1:0] min_gain;
	logic signed [TW-1:0] weight_t;
	logic signed [TW-1:0] load_t;
	logic signed [TW-1:0] add_t;
	logic [16:0] count_inc;
	logic trend_fall;
	logic trend_rise;

	wdc_trend #(.WEIGHT_BITS(WEIGHT_BITS)) u_trend (
		.saved_load(saved_q),
		.load(weight),
		.tolerance_q8(cfg.tolerance_q8),
		.fall(trend_fall),
		.rise(trend_rise)
	);

	assign elapsed = now_s - start_q;
	assign gain = {{(BW-WEIGHT_BITS){weight[WEIGHT_BITS-1]}}, weight}
		- {{(BW-WEIGHT_BITS){base_q[WEIGHT_BITS-1]}}, base_q};
	assign min_gain = {{(BW-16){1'b0}}, cfg.min_progress};
	assign weight_t = {{(TW-WEIGHT_BITS){weight[WEIGHT_BITS-1]}}, weight};
	assign load_t = {{(TW-WEIGHT_BITS){load_q[WEIGHT_BITS-1]}}, load_q};
	assign add_t = {{(TW-ADD_BITS){1'b0}}, add_amount};
	assign count_inc = {1'b0, count_q} + 17'd1;

	always_comb begin
		charging_nx = charging_q;
		load_nx = load_q;
		target_nx = target_q;
		base_nx = base_q;
		start_nx = start_q;
		count_nx = count_q;
		saved_nx = saved_q;
		rise_nx = rise_q;
		fall_nx = fall_q;
		empty = 1'b0;
		if (cmd == CMD_CHARGE) begin
			base_nx = load_q;
			target_nx = load_t + add_t;
			charging_nx = 1'b1;
			start_nx = now_s;
		end else begin
			load_nx = weight;
			if (charging_q) begin
				if (elapsed >= {16'b0, cfg.release_timeout_s}) begin
					if (gain < min_gain) begin
						charging_nx = 1'b0;
						empty = 1'b1;
					end else begin
						base_nx = weight;
						start_nx = now_s;
					end
				end
				if (weight_t > target_q) begin
					charging_nx = 1'b0;
				end
			end
			if (count_inc >= {1'b0, cfg.trend_period}) begin
				count_nx = 16'd0;
				if (trend_fall) begin
					fall_nx = 1'b1;
					rise_nx = 1'b0;
					saved_nx = weight;
				end else if (trend_rise) begin
					fall_nx = 1'b0;
					rise_nx = 1'b1;
					saved_nx = weight;
				end else begin
					fall_nx = 1'b0;
					rise_nx = 1'b0;
				end
			end else begin
				count_nx = count_inc[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charging_q <= 1'b0;
			load_q <= '0;
			target_q <= TW'(TARGET_RESET);
			base_q <= '0;
			start_q <= '0;
			count_q <= '0;
			saved_q <= '0;
			rise_q <= 1'b0;
			fall_q <= 1'b0;
		end else if (advance) begin
			charging_q <= charging_nx;
			load_q <= load_nx;
			target_q <= target_nx;
			base_q <= base_nx;
			start_q <= start_nx;
			count_q <= count_nx;
			saved_q <= saved_nx;
			rise_q <= rise_nx;
			fall_q <= fall_nx;
		end
	end

	always_comb begin
		flags_nx.motor_on = charging_nx;
		flags_nx.storage_empty = empty;
		flags_nx.load_increased = rise_nx;
		flags_nx.load_decreased = fall_nx;
	end

	assign current_load_nx = load_nx;
	assign reference_load_nx = saved_nx;

endmodule

// ===== hdl/weigh_dispense_controller_top.sv =====
// Top level of the weigh and dispense controller.
//
// Input items arrive on in_valid/in_ready: cmd 0 is a weight sample carried in
// weight, cmd 1 starts a charge of add_amount; now_s is the time in seconds.
// Each item gives exactly one result item on out_valid/out_ready with the motor
// drive, the storage empty pulse, the trend flags and the current and reference
// loads as they stand after that item.
// An accepted item is held in an input register and processed into the output
// register, and out_valid rises when it is written there. One item is taken every
// cycle while the receiver does not stall; the state update between the two
// registers is combinational.
// When the receiver stalls, the result is held and one more item waits in the
// input register; in_ready drops only when both are full.
// Registers are written through cfg_we, cfg_index and cfg_data while the block is
// idle, which the user must keep to and the block does not enforce. Reset clears
// the control state, sets the target to 100 grams and loads default register values.
module weigh_dispense_controller_top import wdc_pkg::*; #(
	parameter int WEIGHT_BITS = 20
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_INDEX_BITS-1:0] cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic cmd,
	input logic signed [WEIGHT_BITS-1:0] weight,
	input logic [ADD_BITS-1:0] add_amount,
	input logic [TIME_BITS-1:0] now_s,
	output logic out_valid,
	input logic out_ready,
	output logic motor_on,
	output logic storage_empty,
	output logic load_increased,
	output logic load_decreased,
	output logic signed [WEIGHT_BITS-1:0] current_load,
	output logic signed [WEIGHT_BITS-1:0] reference_load
);

	cfg_t cfg_q;

	logic vld_s1;
	logic cmd_s1;
	logic signed [WEIGHT_BITS-1:0] weight_s1;
	logic [ADD_BITS-1:0] add_s1;
	logic [TIME_BITS-1:0] now_s1;

	logic vld_s2;
	flags_t flags_s2;
	logic signed [WEIGHT_BITS-1:0] cur_s2;
	logic signed [WEIGHT_BITS-1:0] ref_s2;

	logic advance;
	logic take;
	flags_t flags_nx;
	logic signed [WEIGHT_BITS-1:0] cur_nx;
	logic signed [WEIGHT_BITS-1:0] ref_nx;

	assign advance = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || advance;
	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.release_timeout_s <= RELEASE_TIMEOUT_RESET;
			cfg_q.trend_period <= TREND_PERIOD_RESET;
			cfg_q.tolerance_q8 <= TOLERANCE_RESET;
			cfg_q.min_progress <= MIN_PROGRESS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RELEASE_TIMEOUT: cfg_q.release_timeout_s <= cfg_data;
				REG_TREND_PERIOD: cfg_q.trend_period <= cfg_data;
				REG_TOLERANCE: cfg_q.tolerance_q8 <= cfg_data[7:0];
				REG_MIN_PROGRESS: cfg_q.min_progress <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd;
			weight_s1 <= weight;
			add_s1 <= add_amount;
			now_s1 <= now_s;
		end
	end

	wdc_state #(.WEIGHT_BITS(WEIGHT_BITS)) u_state (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.cfg(cfg_q),
		.cmd(cmd_s1),
		.weight(weight_s1),
		.add_amount(add_s1),
		.now_s(now_s1),
		.flags_nx(flags_nx),
		.current_load_nx(cur_nx),
		.reference_load_nx(ref_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (out_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			flags_s2 <= flags_nx;
			cur_s2 <= cur_nx;
			ref_s2 <= ref_nx;
		end
	end

	assign out_valid = vld_s2;
	assign motor_on = flags_s2.motor_on;
	assign storage_empty = flags_s2.storage_empty;
	assign load_increased = flags_s2.load_increased;
	assign load_decreased = flags_s2.load_decreased;
	assign current_load = cur_s2;
	assign reference_load = ref_s2;

endmodule

// ===== hdl/wdc_checker.sv =====
// Port-level checker of the weigh and dispense controller and its bind.
`include "weigh_dispense_controller_top_macros.svh"

module wdc_checker import wdc_pkg::*; #(
	parameter int WEIGHT_BITS = 20
) (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic motor_on,
	input logic storage_empty,
	input logic load_increased,
	input logic load_decreased,
	input logic signed [WEIGHT_BITS-1:0] current_load,
	input logic signed [WEIGHT_BITS-1:0] reference_load
);

	`WDC_ASSERT_IMP(a_empty_stops_motor, out_valid && storage_empty, !motor_on, "storage empty reported while the motor runs")
	`WDC_ASSERT_IMP(a_trend_exclusive, out_valid, !(load_increased && load_decreased), "load reported as both rising and falling")
	`WDC_ASSERT_IMP(a_no_bubble, out_ready, in_ready, "input stalled while the output side is ready")
	`WDC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(current_load) && $stable(reference_load) && $stable(motor_on), "stalled result item changed")

endmodule

bind weigh_dispense_controller_top wdc_checker #(.WEIGHT_BITS(WEIGHT_BITS)) u_wdc_checker (.*);
